// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/sss_pkg.sv -----
// Shared types, codes and constant tables for the seven-segment serial sender
package sss_pkg;

   localparam int DIGITS      = 4;
   localparam int FRAME_DEPTH = DIGITS + 2;
   localparam int PAIR_DEPTH  = 100;

   // Function codes on the input channel
   localparam logic [2:0] FUNC_TICK   = 3'd0;
   localparam logic [2:0] FUNC_BRIGHT = 3'd1;
   localparam logic [2:0] FUNC_DIGIT  = 3'd2;
   localparam logic [2:0] FUNC_RAW    = 3'd3;
   localparam logic [2:0] FUNC_NUMBER = 3'd4;

   // Controller command bytes
   localparam logic [7:0] CMD_DATA    = 8'h40;
   localparam logic [7:0] CMD_ADDR    = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY = 8'h88;

   // Last frame-store index for each command
   localparam logic [2:0] LAST_BRIGHT = 3'd0;
   localparam logic [2:0] LAST_DIGIT  = 3'd2;
   localparam logic [2:0] LAST_FULL   = 3'(FRAME_DEPTH - 1);

   // Number clamp and split by one hundred (reciprocal multiply)
   localparam logic [13:0] NUMBER_MAX     = 14'd9999;
   localparam logic [12:0] HUNDRED_RECIP  = 13'd5243;
   localparam int          HUNDRED_SHIFT  = 19;
   localparam logic [13:0] HUNDRED        = 14'd100;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_BRIGHT,
      OP_DIGIT,
      OP_RAW,
      OP_NUMBER
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [2:0]              level;
      logic [1:0]              position;
      logic [7:0]              digit_seg;
      logic [DIGITS-1:0][7:0]  raw;
      logic [13:0]             value;
      logic [6:0]              hundreds;
   } item_type;

   // Standard segment code, blank above nine
   function automatic logic [7:0] seg_of(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // Build {tens code, units code} for every value 0..99 by counting
   function automatic logic [PAIR_DEPTH-1:0][15:0] build_pairs();
      logic [PAIR_DEPTH-1:0][15:0] t;
      logic [3:0] tens;
      logic [3:0] units;
      tens  = 4'd0;
      units = 4'd0;
      for (int i = 0; i < PAIR_DEPTH; i++) begin
         t[i] = {seg_of(tens), seg_of(units)};
         if (units == 4'd9) begin
            units = 4'd0;
            tens  = tens + 4'd1;
         end else begin
            units = units + 4'd1;
         end
      end
      return t;
   endfunction

   localparam logic [PAIR_DEPTH-1:0][15:0] SEG_PAIRS = build_pairs();

endpackage

// ----- rtl/sss_front.sv -----
// Front part: accepts items, decodes the function and splits numbers by one hundred
module sss_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_func,
   input  logic [2:0]                req_brightness,
   input  logic [1:0]                req_position,
   input  logic [3:0]                req_digit,
   input  logic [7:0]                req_raw0,
   input  logic [7:0]                req_raw1,
   input  logic [7:0]                req_raw2,
   input  logic [7:0]                req_raw3,
   input  logic signed [15:0]        req_number,
   output logic                      push,
   output sss_pkg::item_type         push_item,
   input  logic                      queue_full
);

   logic                a_valid_ff, a_valid_in;
   logic                b_valid_ff, b_valid_in;
   sss_pkg::item_type   a_item_ff, a_item_in;
   sss_pkg::item_type   b_item_ff, b_item_in;
   logic                b_load;
   logic                a_load;
   logic [13:0]         clamped;
   logic [26:0]         product;

   // Stage handshake: each stage loads when empty or emptying
   assign push      = b_valid_ff && !queue_full;
   assign b_load    = !b_valid_ff || push;
   assign a_load    = !a_valid_ff || b_load;
   assign req_stall = !a_load;
   assign push_item = b_item_ff;

   // Decode and clamp the incoming item, then take the hundreds quotient
   always_comb begin
      a_item_in           = a_item_ff;
      a_item_in.level     = req_brightness;
      a_item_in.position  = req_position;
      a_item_in.digit_seg = sss_pkg::seg_of(req_digit);
      a_item_in.raw       = {req_raw3, req_raw2, req_raw1, req_raw0};
      case (req_func)
         sss_pkg::FUNC_BRIGHT: a_item_in.op = sss_pkg::OP_BRIGHT;
         sss_pkg::FUNC_DIGIT:  a_item_in.op = sss_pkg::OP_DIGIT;
         sss_pkg::FUNC_RAW:    a_item_in.op = sss_pkg::OP_RAW;
         sss_pkg::FUNC_NUMBER: a_item_in.op = sss_pkg::OP_NUMBER;
         default:              a_item_in.op = sss_pkg::OP_TICK;
      endcase
      if (req_number[15]) begin
         clamped = 14'd0;
      end else if (req_number[14:0] > 15'(sss_pkg::NUMBER_MAX)) begin
         clamped = sss_pkg::NUMBER_MAX;
      end else begin
         clamped = req_number[13:0];
      end
      product            = 27'(clamped) * 27'(sss_pkg::HUNDRED_RECIP);
      a_item_in.value    = clamped;
      a_item_in.hundreds = product[sss_pkg::HUNDRED_SHIFT +: 7];
   end

   // Second stage: keep the remainder below one hundred
   always_comb begin
      b_item_in       = a_item_ff;
      b_item_in.value = a_item_ff.value - 14'(a_item_ff.hundreds) * sss_pkg::HUNDRED;
   end

   assign a_valid_in = a_load ? req_valid : a_valid_ff;
   assign b_valid_in = b_load ? a_valid_ff : b_valid_ff;

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_item_ff <= a_item_in;
      end
      if (b_load) begin
         b_item_ff <= b_item_in;
      end
   end

endmodule

// ----- rtl/sss_queue.sv -----
// Two-entry item queue between the front and back parts
module sss_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sss_pkg::item_type   push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output sss_pkg::item_type   head
);

   sss_pkg::item_type   slot_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign full      = count_ff[1];
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // Move pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/sss_back.sv -----
// Back part: loads frames, steps the two-wire waveform and registers each result
module sss_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  sss_pkg::item_type   head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_clk_level,
   output logic                rsp_dio_level,
   output logic                rsp_dio_drive,
   output logic                rsp_busy_res,
   output logic                rsp_rejected
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START1,
      PH_START2,
      PH_BIT_A,
      PH_BIT_B,
      PH_BIT_C,
      PH_ACK_A,
      PH_ACK_B,
      PH_ACK_C,
      PH_STOP_A,
      PH_STOP_B,
      PH_STOP_C
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  frame_count_ff, frame_count_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [2:0]  last_index_ff, last_index_in;
   logic        clock_out_ff, clock_out_in;
   logic        data_out_ff, data_out_in;
   logic        data_drive_ff, data_drive_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        clk_level_ff, clk_level_in;
   logic        dio_level_ff, dio_level_in;
   logic        dio_drive_ff, dio_drive_in;
   logic        busy_ff, busy_in;
   logic        rejected_ff, rejected_in;
   logic [7:0]  frame_ff [sss_pkg::FRAME_DEPTH];
   logic [7:0]  frame_in [sss_pkg::FRAME_DEPTH];
   logic [7:0]  cur_byte;
   logic [1:0]  count_dec;
   logic [15:0] pair_hi;
   logic [15:0] pair_lo;

   // Take the head item whenever the result register is free or draining
   assign pop      = not_empty && (!rsp_valid_ff || !rsp_stall);
   assign cur_byte = frame_ff[byte_index_ff];
   assign count_dec = (frame_count_ff != 2'd0) ? frame_count_ff - 2'd1 : 2'd0;
   assign pair_hi  = sss_pkg::SEG_PAIRS[head.hundreds];
   assign pair_lo  = sss_pkg::SEG_PAIRS[head.value[6:0]];

   // Next state: load a frame on a command when idle, refuse it otherwise, step the waveform on a tick
   always_comb begin
      phase_in       = phase_ff;
      frame_count_in = frame_count_ff;
      byte_index_in  = byte_index_ff;
      bit_index_in   = bit_index_ff;
      last_index_in  = last_index_ff;
      clock_out_in   = clock_out_ff;
      data_out_in    = data_out_ff;
      data_drive_in  = data_drive_ff;
      frame_in       = frame_ff;
      rejected_in    = 1'b0;

      if (pop) begin
         if (head.op == sss_pkg::OP_TICK) begin
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_START1: begin
                  data_drive_in = 1'b1;
                  data_out_in   = 1'b1;
                  clock_out_in  = 1'b1;
                  phase_in      = PH_START2;
               end
               PH_START2: begin
                  data_out_in  = 1'b0;
                  bit_index_in = 4'd0;
                  phase_in     = PH_BIT_A;
               end
               PH_BIT_A: begin
                  clock_out_in = 1'b0;
                  phase_in     = PH_BIT_B;
               end
               PH_BIT_B: begin
                  data_drive_in = 1'b1;
                  data_out_in   = cur_byte[bit_index_ff[2:0]];
                  phase_in      = PH_BIT_C;
               end
               PH_BIT_C: begin
                  clock_out_in = 1'b1;
                  bit_index_in = bit_index_ff + 4'd1;
                  phase_in     = (bit_index_in >= 4'd8) ? PH_ACK_A : PH_BIT_A;
               end
               PH_ACK_A: begin
                  clock_out_in  = 1'b0;
                  data_drive_in = 1'b0;
                  phase_in      = PH_ACK_B;
               end
               PH_ACK_B: begin
                  clock_out_in = 1'b1;
                  phase_in     = PH_ACK_C;
               end
               PH_ACK_C: begin
                  clock_out_in = 1'b0;
                  if (frame_count_ff >= 2'd2 || byte_index_ff >= last_index_ff) begin
                     phase_in = PH_STOP_A;
                  end else begin
                     byte_index_in = byte_index_ff + 3'd1;
                     bit_index_in  = 4'd0;
                     phase_in      = PH_BIT_A;
                  end
               end
               PH_STOP_A: begin
                  data_drive_in = 1'b1;
                  data_out_in   = 1'b0;
                  clock_out_in  = 1'b0;
                  phase_in      = PH_STOP_B;
               end
               PH_STOP_B: begin
                  clock_out_in = 1'b1;
                  phase_in     = PH_STOP_C;
               end
               PH_STOP_C: begin
                  data_out_in = 1'b1;
                  if (count_dec != 2'd0 && byte_index_ff < last_index_ff) begin
                     frame_count_in = count_dec;
                     byte_index_in  = byte_index_ff + 3'd1;
                     phase_in       = PH_START1;
                  end else begin
                     frame_count_in = 2'd0;
                     phase_in       = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end else if (phase_ff != PH_IDLE) begin
            // Drop commands while a transaction runs
            rejected_in = 1'b1;
         end else begin
            byte_index_in = 3'd0;
            bit_index_in  = 4'd0;
            phase_in      = PH_START1;
            case (head.op)
               sss_pkg::OP_BRIGHT: begin
                  frame_in[0]    = sss_pkg::CMD_DISPLAY | {5'd0, head.level};
                  frame_count_in = 2'd1;
                  last_index_in  = sss_pkg::LAST_BRIGHT;
               end
               sss_pkg::OP_DIGIT: begin
                  frame_in[0]    = sss_pkg::CMD_DATA;
                  frame_in[1]    = sss_pkg::CMD_ADDR | {6'd0, head.position};
                  frame_in[2]    = head.digit_seg;
                  frame_count_in = 2'd2;
                  last_index_in  = sss_pkg::LAST_DIGIT;
               end
               sss_pkg::OP_RAW: begin
                  frame_in[0] = sss_pkg::CMD_DATA;
                  frame_in[1] = sss_pkg::CMD_ADDR;
                  for (int i = 0; i < sss_pkg::DIGITS; i++) begin
                     frame_in[i + 2] = head.raw[i];
                  end
                  frame_count_in = 2'd2;
                  last_index_in  = sss_pkg::LAST_FULL;
               end
               default: begin
                  frame_in[0]    = sss_pkg::CMD_DATA;
                  frame_in[1]    = sss_pkg::CMD_ADDR;
                  frame_in[2]    = pair_hi[15:8];
                  frame_in[3]    = pair_hi[7:0];
                  frame_in[4]    = pair_lo[15:8];
                  frame_in[5]    = pair_lo[7:0];
                  frame_count_in = 2'd2;
                  last_index_in  = sss_pkg::LAST_FULL;
               end
            endcase
         end
      end

      // Result fields show the pins after this item
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
      clk_level_in = pop ? clock_out_in : clk_level_ff;
      dio_level_in = pop ? (data_drive_in & data_out_in) : dio_level_ff;
      dio_drive_in = pop ? data_drive_in : dio_drive_ff;
      busy_in      = pop ? (phase_in != PH_IDLE) : busy_ff;
      rejected_in  = pop ? rejected_in : rejected_ff;
   end

   // Hold state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         frame_count_ff <= 2'd0;
         byte_index_ff  <= 3'd0;
         bit_index_ff   <= 4'd0;
         last_index_ff  <= 3'd0;
         clock_out_ff   <= 1'b1;
         data_out_ff    <= 1'b1;
         data_drive_ff  <= 1'b1;
         rsp_valid_ff   <= 1'b0;
         clk_level_ff   <= 1'b1;
         dio_level_ff   <= 1'b1;
         dio_drive_ff   <= 1'b1;
         busy_ff        <= 1'b0;
         rejected_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         frame_count_ff <= frame_count_in;
         byte_index_ff  <= byte_index_in;
         bit_index_ff   <= bit_index_in;
         last_index_ff  <= last_index_in;
         clock_out_ff   <= clock_out_in;
         data_out_ff    <= data_out_in;
         data_drive_ff  <= data_drive_in;
         rsp_valid_ff   <= rsp_valid_in;
         clk_level_ff   <= clk_level_in;
         dio_level_ff   <= dio_level_in;
         dio_drive_ff   <= dio_drive_in;
         busy_ff        <= busy_in;
         rejected_ff    <= rejected_in;
      end
   end

   // Frame store, written only by an accepted command
   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_clk_level = clk_level_ff;
   assign rsp_dio_level = dio_level_ff;
   assign rsp_dio_drive = dio_drive_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_rejected  = rejected_ff;

endmodule

// ----- rtl/seven_segment_serial_sender.sv -----
// Top level of the two-wire seven-segment serial sender
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  func, brightness, position, digit, raw0..3, number
//   rsp      out  rsp_valid / rsp_stall  clk_level, dio_level, dio_drive, busy_res, rejected
//
// One item per cycle sustained while rsp is not stalled; every item gives one result.
// After its item is accepted, a result passes through two front stages
// (decode/clamp with the hundreds multiply, then the remainder), the queue slot,
// and the back part's result register.
// Reset is synchronous and active high; it empties both parts and idles the pins high.
// A stall on rsp holds the result register; the two-entry queue and the front
// stages absorb items before req_stall rises.
module seven_segment_serial_sender (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic [2:0]          req_brightness,
   input  logic [1:0]          req_position,
   input  logic [3:0]          req_digit,
   input  logic [7:0]          req_raw0,
   input  logic [7:0]          req_raw1,
   input  logic [7:0]          req_raw2,
   input  logic [7:0]          req_raw3,
   input  logic signed [15:0]  req_number,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_clk_level,
   output logic                rsp_dio_level,
   output logic                rsp_dio_drive,
   output logic                rsp_busy_res,
   output logic                rsp_rejected
);

   logic                push;
   logic                queue_full;
   logic                pop;
   logic                not_empty;
   sss_pkg::item_type   push_item;
   sss_pkg::item_type   head;

   // Accept and classify items
   sss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_brightness (req_brightness),
      .req_position   (req_position),
      .req_digit      (req_digit),
      .req_raw0       (req_raw0),
      .req_raw1       (req_raw1),
      .req_raw2       (req_raw2),
      .req_raw3       (req_raw3),
      .req_number     (req_number),
      .push           (push),
      .push_item      (push_item),
      .queue_full     (queue_full)
   );

   // Decouple front and back
   sss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   // Run the link waveform
   sss_back u_back (
      .clock         (clock),
      .reset         (reset),
      .not_empty     (not_empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_clk_level (rsp_clk_level),
      .rsp_dio_level (rsp_dio_level),
      .rsp_dio_drive (rsp_dio_drive),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_rejected  (rsp_rejected)
   );

endmodule

// ----- rtl/sss_checker.sv -----
// Port-level checks for the seven-segment serial sender, bound to the top level
`include "assert_macros.svh"

module sss_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_clk_level,
   input logic                rsp_dio_level,
   input logic                rsp_dio_drive,
   input logic                rsp_busy_res,
   input logic                rsp_rejected
);

   // A refused command only happens while a transaction runs
   `ASSERT_IMPLIES(a_reject_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res)

   // A released data line reads low
   `ASSERT_IMPLIES(a_release_low, clock, reset, rsp_valid && !rsp_dio_drive, !rsp_dio_level)

   // Between transactions both lines idle high and driven
   `ASSERT_IMPLIES(a_idle_pins, clock, reset, rsp_valid && !rsp_busy_res,
                   rsp_clk_level && rsp_dio_level && rsp_dio_drive)

   // A stalled result stays offered and unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_clk_level) && $stable(rsp_dio_level)
                && $stable(rsp_dio_drive) && $stable(rsp_busy_res) && $stable(rsp_rejected))

endmodule

bind seven_segment_serial_sender sss_checker u_checker (.*);

// ----- sim/segment_link_checker.sv -----
// Checker for the seven-segment serial sender: predicts the pin levels of every item and compares
`timescale 1ns / 1ps

module segment_link_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [2:0]         req_brightness,
   input  logic [1:0]         req_position,
   input  logic [3:0]         req_digit,
   input  logic [7:0]         req_raw0,
   input  logic [7:0]         req_raw1,
   input  logic [7:0]         req_raw2,
   input  logic [7:0]         req_raw3,
   input  logic signed [15:0] req_number,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_clk_level,
   input  logic               rsp_dio_level,
   input  logic               rsp_dio_drive,
   input  logic               rsp_busy_res,
   input  logic               rsp_rejected,
   output int                 fail_count,
   output int                 pending,
   output int                 results_checked
);

   localparam int NUMBER_CEILING = 9999;

   // Steps of the two-wire waveform
   typedef enum logic [3:0] {
      LINE_IDLE,
      START_HIGH,
      START_LOW,
      BIT_CLK_LOW,
      BIT_DATA,
      BIT_CLK_HIGH,
      ACK_CLK_LOW,
      ACK_CLK_HIGH,
      ACK_CLK_END,
      STOP_DATA_LOW,
      STOP_CLK_HIGH,
      STOP_DATA_HIGH
   } line_phase_type;

   typedef struct packed {
      logic clk_level;
      logic dio_level;
      logic dio_drive;
      logic busy;
      logic rejected;
   } pins_type;

   logic [7:0]     frame_store [sss_pkg::FRAME_DEPTH];
   logic [1:0]     frames_left;
   logic [2:0]     byte_pos;
   logic [2:0]     last_pos;
   logic [3:0]     bit_pos;
   line_phase_type line_phase;
   logic           clk_out;
   logic           dio_out;
   logic           dio_en;
   pins_type       expected_pins [$];

   // Standard seven-segment pattern, blank outside 0..9
   function automatic logic [7:0] segment_code(input int d);
      case (d)
         0:       return 8'h3F;
         1:       return 8'h06;
         2:       return 8'h5B;
         3:       return 8'h4F;
         4:       return 8'h66;
         5:       return 8'h6D;
         6:       return 8'h7D;
         7:       return 8'h07;
         8:       return 8'h7F;
         9:       return 8'h6F;
         default: return 8'h00;
      endcase
   endfunction

   // Load a command or step the waveform, then queue the pin levels it leaves
   task automatic predict_pins(input logic [2:0] func, input logic [2:0] level,
                               input logic [1:0] pos, input logic [3:0] dig,
                               input logic [7:0] r0, input logic [7:0] r1,
                               input logic [7:0] r2, input logic [7:0] r3,
                               input logic signed [15:0] num);
      int       value;
      logic     refused;
      pins_type pins;
      refused = 1'b0;
      if (func >= sss_pkg::FUNC_BRIGHT && func <= sss_pkg::FUNC_NUMBER) begin
         if (line_phase != LINE_IDLE) begin
            refused = 1'b1;
         end else begin
            case (func)
               sss_pkg::FUNC_BRIGHT: begin
                  frame_store[0] = sss_pkg::CMD_DISPLAY + level;
                  last_pos = sss_pkg::LAST_BRIGHT;
               end
               sss_pkg::FUNC_DIGIT: begin
                  frame_store[1] = sss_pkg::CMD_ADDR + pos;
                  frame_store[2] = segment_code(dig);
                  last_pos = sss_pkg::LAST_DIGIT;
               end
               sss_pkg::FUNC_RAW: begin
                  frame_store[1] = sss_pkg::CMD_ADDR;
                  frame_store[2] = r0;
                  frame_store[3] = r1;
                  frame_store[4] = r2;
                  frame_store[5] = r3;
                  last_pos = sss_pkg::LAST_FULL;
               end
               default: begin
                  // clamp to the four-digit range, then split into decimal digits
                  value = num;
                  if (value < 0) value = 0;
                  else if (value > NUMBER_CEILING) value = NUMBER_CEILING;
                  frame_store[1] = sss_pkg::CMD_ADDR;
                  frame_store[2] = segment_code(value / 1000);
                  frame_store[3] = segment_code((value / 100) % 10);
                  frame_store[4] = segment_code((value / 10) % 10);
                  frame_store[5] = segment_code(value % 10);
                  last_pos = sss_pkg::LAST_FULL;
               end
            endcase
            if (func == sss_pkg::FUNC_BRIGHT) begin
               frames_left = 2'd1;
            end else begin
               frame_store[0] = sss_pkg::CMD_DATA;
               frames_left = 2'd2;
            end
            byte_pos = 3'd0;
            bit_pos = 4'd0;
            line_phase = START_HIGH;
         end
      end else begin
         // tick or spare code: advance one waveform step
         case (line_phase)
            START_HIGH: begin
               dio_en = 1'b1;
               dio_out = 1'b1;
               clk_out = 1'b1;
               line_phase = START_LOW;
            end
            START_LOW: begin
               dio_out = 1'b0;
               bit_pos = 4'd0;
               line_phase = BIT_CLK_LOW;
            end
            BIT_CLK_LOW: begin
               clk_out = 1'b0;
               line_phase = BIT_DATA;
            end
            BIT_DATA: begin
               dio_en = 1'b1;
               dio_out = frame_store[byte_pos][bit_pos[2:0]];
               line_phase = BIT_CLK_HIGH;
            end
            BIT_CLK_HIGH: begin
               clk_out = 1'b1;
               bit_pos = bit_pos + 4'd1;
               line_phase = (bit_pos >= 4'd8) ? ACK_CLK_LOW : BIT_CLK_LOW;
            end
            ACK_CLK_LOW: begin
               clk_out = 1'b0;
               dio_en = 1'b0;
               line_phase = ACK_CLK_HIGH;
            end
            ACK_CLK_HIGH: begin
               clk_out = 1'b1;
               line_phase = ACK_CLK_END;
            end
            ACK_CLK_END: begin
               clk_out = 1'b0;
               if (frames_left >= 2'd2 || byte_pos >= last_pos) begin
                  line_phase = STOP_DATA_LOW;
               end else begin
                  byte_pos = byte_pos + 3'd1;
                  bit_pos = 4'd0;
                  line_phase = BIT_CLK_LOW;
               end
            end
            STOP_DATA_LOW: begin
               dio_en = 1'b1;
               dio_out = 1'b0;
               clk_out = 1'b0;
               line_phase = STOP_CLK_HIGH;
            end
            STOP_CLK_HIGH: begin
               clk_out = 1'b1;
               line_phase = STOP_DATA_HIGH;
            end
            STOP_DATA_HIGH: begin
               // end of a frame: open the next one or go idle
               dio_out = 1'b1;
               if (frames_left != 2'd0) frames_left = frames_left - 2'd1;
               if (frames_left != 2'd0 && byte_pos < last_pos) begin
                  byte_pos = byte_pos + 3'd1;
                  line_phase = START_HIGH;
               end else begin
                  frames_left = 2'd0;
                  line_phase = LINE_IDLE;
               end
            end
            default: ;
         endcase
      end
      pins.clk_level = clk_out;
      pins.dio_level = dio_en ? dio_out : 1'b0;
      pins.dio_drive = dio_en;
      pins.busy = (line_phase != LINE_IDLE);
      pins.rejected = refused;
      expected_pins.push_back(pins);
   endtask

   task automatic compare_bit(input string field, input logic want, input logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, actual %0b", field, want, got);
         fail_count++;
      end
   endtask

   // Watch both channels: predict on each accepted item, compare each accepted result
   always @(posedge clock) begin : watch
      pins_type want;
      if (reset) begin
         frames_left = 2'd0;
         byte_pos = 3'd0;
         last_pos = 3'd0;
         bit_pos = 4'd0;
         line_phase = LINE_IDLE;
         clk_out = 1'b1;
         dio_out = 1'b1;
         dio_en = 1'b1;
         expected_pins.delete();
         fail_count = 0;
         results_checked = 0;
      end else begin
         if (req_valid && !req_stall)
            predict_pins(req_func, req_brightness, req_position, req_digit,
                         req_raw0, req_raw1, req_raw2, req_raw3, req_number);
         if (rsp_valid && !rsp_stall) begin
            if (expected_pins.size() == 0) begin
               $error("result item arrived with no expected result waiting");
               fail_count++;
            end else begin
               want = expected_pins.pop_front();
               compare_bit("rsp_clk_level", want.clk_level, rsp_clk_level);
               compare_bit("rsp_dio_level", want.dio_level, rsp_dio_level);
               compare_bit("rsp_dio_drive", want.dio_drive, rsp_dio_drive);
               compare_bit("rsp_busy_res", want.busy, rsp_busy_res);
               compare_bit("rsp_rejected", want.rejected, rsp_rejected);
               results_checked++;
            end
         end
      end
      pending = expected_pins.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the seven-segment serial sender: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
   // Ticks from command to idle: one frame, one plus two bytes, one plus five bytes
   localparam int BRIGHT_TICKS   = 32;
   localparam int DIGIT_TICKS    = 91;
   localparam int FULL_TICKS     = 172;
   localparam int RANDOM_ITEMS   = 720;
   localparam int WATCHDOG_LIMIT = 1000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_func = sss_pkg::FUNC_TICK;
   logic [2:0]         req_brightness = '0;
   logic [1:0]         req_position = '0;
   logic [3:0]         req_digit = '0;
   logic [7:0]         req_raw0 = '0;
   logic [7:0]         req_raw1 = '0;
   logic [7:0]         req_raw2 = '0;
   logic [7:0]         req_raw3 = '0;
   logic signed [15:0] req_number = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_clk_level;
   logic               rsp_dio_level;
   logic               rsp_dio_drive;
   logic               rsp_busy_res;
   logic               rsp_rejected;
   int                 fail_count;
   int                 pending;
   int                 results_checked;

   int send_idle_pct = 16;
   int stall_pct = 77;
   int items_sent = 0;
   int quiet_cycles = 0;

   seven_segment_serial_sender dut (.*);

   segment_link_checker line_check (.*);

   always #6 clock = ~clock;

   // Receiver side: stall at random
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Watchdog: end the run when nothing is accepted for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int ticks_for(input logic [2:0] f);
      case (f)
         sss_pkg::FUNC_BRIGHT: return BRIGHT_TICKS;
         sss_pkg::FUNC_DIGIT:  return DIGIT_TICKS;
         default:              return FULL_TICKS;
      endcase
   endfunction

   // Present one item after a random gap and hold it until it is taken
   task automatic send_item(input logic [2:0] f, input logic [2:0] b, input logic [1:0] p,
                            input logic [3:0] d, input logic [7:0] r0, input logic [7:0] r1,
                            input logic [7:0] r2, input logic [7:0] r3,
                            input logic signed [15:0] n);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_brightness <= b;
      req_position <= p;
      req_digit <= d;
      req_raw0 <= r0;
      req_raw1 <= r1;
      req_raw2 <= r2;
      req_raw3 <= r3;
      req_number <= n;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task automatic send_random(input logic [2:0] f);
      send_item(f, 3'($urandom), 2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   // Issue one command and tick it through; with noise, mix in refusals,
   // spare tick codes and the odd cut-short transaction
   task automatic run_command(input logic [2:0] f, input logic [2:0] b, input logic [1:0] p,
                              input logic [3:0] d, input logic [7:0] r0, input logic [7:0] r1,
                              input logic [7:0] r2, input logic [7:0] r3,
                              input logic signed [15:0] n, input logic noisy,
                              output int sent);
      int         span;
      logic [2:0] code;
      send_item(f, b, p, d, r0, r1, r2, r3, n);
      sent = 1;
      span = ticks_for(f);
      if (noisy && $urandom_range(9) == 0) span = $urandom_range(1, span);
      for (int i = 0; i < span; i++) begin
         if (noisy && $urandom_range(24) == 0)
            send_random(3'($urandom_range(sss_pkg::FUNC_BRIGHT, sss_pkg::FUNC_NUMBER)));
         code = (noisy && $urandom_range(9) == 0) ?
                3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)) : sss_pkg::FUNC_TICK;
         send_random(code);
         sent++;
      end
   endtask

   task automatic random_command(output int sent);
      logic [2:0]         f;
      logic signed [15:0] n;
      f = 3'($urandom_range(sss_pkg::FUNC_BRIGHT, sss_pkg::FUNC_NUMBER));
      case ($urandom_range(3))
         0:       n = 16'($urandom);
         1:       n = 16'($urandom_range(0, 9999));
         2:       n = 16'($urandom_range(9990, 10010));
         default: n = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
      endcase
      run_command(f, 3'($urandom), 2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), n, 1'b1, sent);
   endtask

   initial begin
      int sent;
      int busy_items;
      busy_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle ticks, refusal while busy, spare codes, field extremes
      send_random(sss_pkg::FUNC_TICK);
      send_random(FUNC_SPARE_LAST);
      send_item(sss_pkg::FUNC_BRIGHT, 3'd7, 2'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0);
      send_random(sss_pkg::FUNC_NUMBER);
      for (int i = 0; i < BRIGHT_TICKS; i++)
         send_random(i < 3 ? 3'(FUNC_SPARE_FIRST + i) : sss_pkg::FUNC_TICK);
      run_command(sss_pkg::FUNC_BRIGHT, 3'd0, 2'd3, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  -16'sd1, 1'b0, sent);
      run_command(sss_pkg::FUNC_DIGIT, 3'd0, 2'd2, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00,
                  16'sd0, 1'b0, sent);
      run_command(sss_pkg::FUNC_RAW, 3'd0, 2'd0, 4'd0, 8'h00, 8'hFF, 8'hA5, 8'h5A,
                  16'sd0, 1'b0, sent);
      run_command(sss_pkg::FUNC_NUMBER, 3'd0, 2'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                  16'sh8000, 1'b0, sent);
      run_command(sss_pkg::FUNC_NUMBER, 3'd0, 2'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                  16'sh7FFF, 1'b0, sent);

      // Random commands; swap the idle mix each third, then run with no idling
      while (busy_items < RANDOM_ITEMS) begin
         if (busy_items >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            stall_pct = 0;
         end else if (busy_items >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 77;
            stall_pct = 16;
         end
         random_command(sent);
         busy_items += sent;
      end
      req_valid <= 1'b0;

      // Drain outstanding results, then leave time for stray results
      do @(negedge clock); while (pending != 0);
      repeat (8) @(negedge clock);

      $display("Run covered %0d items: every command with edge fields, refusals while busy,",
               items_sent);
      $display("spare tick codes and cut-short transactions; %0d results compared",
               results_checked);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
